@@ rtl/tcw_pkg.sv @@
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int CELL_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_FG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG = 2'd1;

    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] RESET_ATTR = 8'hF0;

    typedef enum logic [2:0] {
        OP_PUT   = 3'd0,
        OP_MOVE  = 3'd1,
        OP_SYNC  = 3'd2,
        OP_CLEAR = 3'd3,
        OP_READ  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        PM_HOLD,
        PM_MAP,
        PM_INC,
        PM_ZERO
    } pos_mode_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_RDWAIT,
        ST_SCROLL,
        ST_FILL,
        ST_CLR
    } state_t;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] char_code;
        logic [7:0] col;
        logic [7:0] row;
    } cmd_t;

    typedef struct packed {
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic [10:0] hw_cursor_pos;
        logic [7:0]  cell_char;
        logic [7:0]  cell_attr;
        logic        scrolled;
        logic        ignored;
    } rsp_t;

endpackage

@@ rtl/text_console_writer_unit.sv @@
`timescale 1ns / 1ps

// Text console: put char / newline strobe the result in the cycle after their work cycle, unless they scroll.
// Move, sync and out-of-range read do likewise; an in-range read waits in ST_RDWAIT (registered RAM port).
// Scroll copies each row up and blanks the bottom row; clear blanks every cell; the RAM takes one write per cycle.
// After reset the store is swept to blanks (busy high); config writes still taken.
// One request in flight; done pulses for one cycle and the receiver cannot stall it.
module text_console_writer_unit #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  tcw_pkg::cmd_t                    cmd,
    output logic                             done,
    output tcw_pkg::rsp_t                    result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CW    = $clog2(COLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CELLS = COLS * ROWS;
    localparam int AW    = $clog2(CELLS);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    tcw_pkg::state_t state_reg, state_next;

    tcw_pkg::op_t    op_reg;
    logic [7:0]      ch_reg;
    logic [7:0]      col_in_reg;
    logic [7:0]      row_in_reg;

    logic [CW-1:0]   cur_col_reg, cur_col_next;
    logic [RW-1:0]   cur_row_reg, cur_row_next;
    logic [AW-1:0]   shown_pos_reg, shown_pos_next;
    logic            scrolled_reg, scrolled_next;
    logic            ignored_reg, ignored_next;

    logic [3:0]      fg_reg;
    logic [3:0]      bg_reg;

    // scroll copy pipeline: read at dst + COLS, write dst in the next cycle
    logic            copy_pend_reg;
    logic [AW-1:0]   copy_dst_reg;

    tcw_pkg::rsp_t   rsp_reg, rsp_next;
    logic            done_reg;

    // ------------------------------------------------------------------
    // Shared position unit and cell store
    // ------------------------------------------------------------------
    tcw_pkg::pos_mode_t pos_mode;
    logic [RW-1:0]      map_row;
    logic [CW-1:0]      map_col;
    logic [AW-1:0]      pos;

    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [tcw_pkg::CELL_W-1:0] mem_wdata;
    logic [AW-1:0]              mem_raddr;
    logic [tcw_pkg::CELL_W-1:0] mem_rdata;

    tcw_pos_unit #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_pos (
        .clk   (clk),
        .rst_n (rst_n),
        .mode  (pos_mode),
        .row   (map_row),
        .col   (map_col),
        .pos   (pos)
    );

    tcw_cell_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // ------------------------------------------------------------------
    // Decode helpers
    // ------------------------------------------------------------------
    logic           accept;
    tcw_pkg::op_t   start_op;
    logic           put_nl;
    logic           col_last;
    logic           row_last;
    logic           wrap;
    logic           in_range;
    logic           end_copy;
    logic           end_all;
    logic [7:0]     attr;
    logic           fin;

    assign accept   = start && !busy;
    assign start_op = tcw_pkg::op_t'(cmd.op);
    assign put_nl   = (ch_reg == tcw_pkg::CHAR_NL);
    assign col_last = (cur_col_reg == CW'(COLS - 1));
    assign row_last = (cur_row_reg == RW'(ROWS - 1));
    assign wrap     = put_nl || col_last;
    assign in_range = ({1'b0, col_in_reg} < 9'(COLS)) && ({1'b0, row_in_reg} < 9'(ROWS));
    assign end_copy = (pos == AW'(CELLS - COLS - 1));
    assign end_all  = (pos == AW'(CELLS - 1));
    assign attr     = {fg_reg, bg_reg};

    // Move and read map the requested position; put and sync map the cursor, clear zeroes it.
    always_comb
    begin
        if (start_op == tcw_pkg::OP_MOVE || start_op == tcw_pkg::OP_READ)
        begin
            map_row = RW'(cmd.row);
            map_col = CW'(cmd.col);
        end
        else
        begin
            map_row = cur_row_reg;
            map_col = cur_col_reg;
        end
    end

    // During a scroll the read runs one row ahead of the write.
    assign mem_raddr = (state_reg == tcw_pkg::ST_SCROLL) ? AW'(pos + AW'(COLS)) : pos;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tcw_pkg::ST_INIT:
            begin
                if (end_all)
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = tcw_pkg::ST_EXEC;
                end
            end
            tcw_pkg::ST_EXEC:
            begin
                case (op_reg)
                    tcw_pkg::OP_PUT:
                    begin
                        state_next = (wrap && row_last) ? tcw_pkg::ST_SCROLL
                                                        : tcw_pkg::ST_IDLE;
                    end
                    tcw_pkg::OP_CLEAR: state_next = tcw_pkg::ST_CLR;
                    tcw_pkg::OP_READ:
                    begin
                        state_next = in_range ? tcw_pkg::ST_RDWAIT : tcw_pkg::ST_IDLE;
                    end
                    default:           state_next = tcw_pkg::ST_IDLE;
                endcase
            end
            tcw_pkg::ST_RDWAIT: state_next = tcw_pkg::ST_IDLE;
            tcw_pkg::ST_SCROLL:
            begin
                if (end_copy)
                begin
                    state_next = tcw_pkg::ST_FILL;
                end
            end
            tcw_pkg::ST_FILL:
            begin
                if (!copy_pend_reg && end_all)
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_CLR:
            begin
                if (end_all)
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            default: state_next = tcw_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs of the sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        pos_mode       = tcw_pkg::PM_HOLD;
        mem_we         = 1'b0;
        mem_waddr      = pos;
        mem_wdata      = {attr, tcw_pkg::CHAR_SPACE};
        fin            = 1'b0;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        shown_pos_next = shown_pos_reg;
        scrolled_next  = scrolled_reg;
        ignored_next   = ignored_reg;

        case (state_reg)
            tcw_pkg::ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = {tcw_pkg::RESET_ATTR, tcw_pkg::CHAR_SPACE};
                pos_mode  = tcw_pkg::PM_INC;
            end
            tcw_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    pos_mode      = (start_op == tcw_pkg::OP_CLEAR) ? tcw_pkg::PM_ZERO
                                                                    : tcw_pkg::PM_MAP;
                    scrolled_next = 1'b0;
                    ignored_next  = 1'b0;
                end
            end
            tcw_pkg::ST_EXEC:
            begin
                case (op_reg)
                    tcw_pkg::OP_PUT:
                    begin
                        if (!put_nl)
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {attr, ch_reg};
                        end
                        if (wrap)
                        begin
                            cur_col_next = '0;
                            if (row_last)
                            begin
                                scrolled_next = 1'b1;
                                pos_mode      = tcw_pkg::PM_ZERO;
                            end
                            else
                            begin
                                cur_row_next = cur_row_reg + RW'(1);
                                fin          = 1'b1;
                            end
                        end
                        else
                        begin
                            cur_col_next = cur_col_reg + CW'(1);
                            fin          = 1'b1;
                        end
                    end
                    tcw_pkg::OP_MOVE:
                    begin
                        if (in_range)
                        begin
                            cur_col_next   = CW'(col_in_reg);
                            cur_row_next   = RW'(row_in_reg);
                            shown_pos_next = pos;
                        end
                        else
                        begin
                            ignored_next = 1'b1;
                        end
                        fin = 1'b1;
                    end
                    tcw_pkg::OP_SYNC:
                    begin
                        shown_pos_next = pos;
                        fin            = 1'b1;
                    end
                    tcw_pkg::OP_CLEAR:
                    begin
                        cur_col_next   = '0;
                        cur_row_next   = '0;
                        shown_pos_next = '0;
                    end
                    tcw_pkg::OP_READ:
                    begin
                        if (!in_range)
                        begin
                            ignored_next = 1'b1;
                            fin          = 1'b1;
                        end
                    end
                    default: fin = 1'b1;
                endcase
            end
            tcw_pkg::ST_RDWAIT: fin = 1'b1;
            tcw_pkg::ST_SCROLL: pos_mode = tcw_pkg::PM_INC;
            tcw_pkg::ST_FILL:
            begin
                // last copy write drains first, then the bottom row is blanked
                if (!copy_pend_reg)
                begin
                    mem_we   = 1'b1;
                    pos_mode = tcw_pkg::PM_INC;
                    fin      = end_all;
                end
            end
            tcw_pkg::ST_CLR:
            begin
                mem_we   = 1'b1;
                pos_mode = tcw_pkg::PM_INC;
                fin      = end_all;
            end
            default: fin = 1'b0;
        endcase

        // copy write owns the port whenever one is pending
        if (copy_pend_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = copy_dst_reg;
            mem_wdata = mem_rdata;
        end
    end

    assign busy = (state_reg != tcw_pkg::ST_IDLE);

    // Result built from the next-state values so it leaves with the final work cycle.
    always_comb
    begin
        rsp_next               = '0;
        rsp_next.cursor_col    = 7'(cur_col_next);
        rsp_next.cursor_row    = 5'(cur_row_next);
        rsp_next.hw_cursor_pos = 11'(shown_pos_next);
        rsp_next.scrolled      = scrolled_next;
        rsp_next.ignored       = ignored_next;
        if (state_reg == tcw_pkg::ST_RDWAIT)
        begin
            rsp_next.cell_char = mem_rdata[7:0];
            rsp_next.cell_attr = mem_rdata[15:8];
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcw_pkg::ST_INIT;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            shown_pos_reg <= '0;
            scrolled_reg  <= 1'b0;
            ignored_reg   <= 1'b0;
            copy_pend_reg <= 1'b0;
            done_reg      <= 1'b0;
            fg_reg        <= 4'hF;
            bg_reg        <= 4'h0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            shown_pos_reg <= shown_pos_next;
            scrolled_reg  <= scrolled_next;
            ignored_reg   <= ignored_next;
            copy_pend_reg <= (state_reg == tcw_pkg::ST_SCROLL);
            done_reg      <= fin;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    tcw_pkg::CFG_FG: fg_reg <= cfg_data;
                    tcw_pkg::CFG_BG: bg_reg <= cfg_data;
                    default:         fg_reg <= fg_reg;
                endcase
            end
        end
    end

    // request capture, copy destination and result payload
    always_ff @(posedge clk)
    begin
        copy_dst_reg <= pos;
        if (accept)
        begin
            op_reg     <= start_op;
            ch_reg     <= cmd.char_code;
            col_in_reg <= cmd.col;
            row_in_reg <= cmd.row;
        end
        if (fin)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = rsp_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$past(state_reg == tcw_pkg::ST_IDLE))
        else $error("result strobe without a work cycle");

    a_copy_in_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        copy_pend_reg |-> (state_reg == tcw_pkg::ST_SCROLL || state_reg == tcw_pkg::ST_FILL))
        else $error("scroll copy pending outside scroll");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, cur_col_reg} < (CW + 1)'(COLS)) && ({1'b0, cur_row_reg} < (RW + 1)'(ROWS)))
        else $error("cursor out of range");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but unit not busy");

endmodule

@@ rtl/tcw_cell_ram.sv @@
`timescale 1ns / 1ps

// Single write port, single registered read port.
module tcw_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [tcw_pkg::CELL_W-1:0] wdata,
    input  logic [AW-1:0]             raddr,
    output logic [tcw_pkg::CELL_W-1:0] rdata
);

    logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/tcw_pos_unit.sv @@
`timescale 1ns / 1ps

// Shared linear-address unit: row * COLS + col, increment, zero or hold.
module tcw_pos_unit #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tcw_pkg::pos_mode_t                   mode,
    input  logic [$clog2(ROWS)-1:0]              row,
    input  logic [$clog2(COLS)-1:0]              col,
    output logic [$clog2(COLS*ROWS)-1:0]         pos
);

    localparam int AW = $clog2(COLS * ROWS);

    logic [AW-1:0] pos_reg;
    logic [AW-1:0] pos_next;

    always_comb
    begin
        case (mode)
            tcw_pkg::PM_MAP:  pos_next = AW'(AW'(row) * AW'(COLS) + AW'(col));
            tcw_pkg::PM_INC:  pos_next = pos_reg + AW'(1);
            tcw_pkg::PM_ZERO: pos_next = '0;
            default:          pos_next = pos_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    assign pos = pos_reg;

endmodule
